### sv/fp32_to_fp16_encoder_macros.svh
// assertion macros for the fp32 to fp16 encoder
// no dependencies; included by the top level
`ifndef FP32_TO_FP16_ENCODER_MACROS_SVH
`define FP32_TO_FP16_ENCODER_MACROS_SVH

// implication in the same cycle
`define F2H_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("f2h assertion failed");

// implication in the next cycle
`define F2H_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("f2h assertion failed");

`endif

### sv/f2h_pkg.sv
// types and constants for the fp32 to fp16 encoder
// no dependencies
`timescale 1ns / 1ps

package f2h_pkg;

    localparam int unsigned SGL_W  = 32;
    localparam int unsigned HALF_W = 16;
    localparam int unsigned EXP_W  = 9;

    // single bias minus half bias
    localparam logic signed [EXP_W-1:0] REBIAS = 9'sd112;

    localparam logic [14:0] HALF_INF_BODY = 15'h7C00;
    localparam logic [14:0] HALF_QUIET    = 15'h0200;

    typedef enum logic [2:0] {
        CLS_ZERO,
        CLS_SUB,
        CLS_NORM,
        CLS_INF,
        CLS_NAN
    } cls_t;

endpackage

### sv/fp32_to_fp16_encoder.sv
// binary32 to binary16 converter, three register stages
// depends on f2h_pkg and fp32_to_fp16_encoder_macros.svh
//
// channel  direction  valid         stall         word
// single   in         single_valid  single_stall  single_bits[31:0]
// half     out        half_valid    half_stall    half_bits[15:0]
//
// one word per cycle sustained while half_stall is low
// stages: classify and rebias, subnormal shift and select, round add
// rst_n clears the stage valid bits only
// a stall on half holds each occupied stage whose later stages are all occupied; empty stages still fill
`timescale 1ns / 1ps
`include "fp32_to_fp16_encoder_macros.svh"

module fp32_to_fp16_encoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        single_valid,
    output logic        single_stall,
    input  logic [31:0] single_bits,
    output logic        half_valid,
    input  logic        half_stall,
    output logic [15:0] half_bits
);

    // stage 1 registers
    logic                                 v1_reg;
    logic                                 sgn1_reg;
    logic [22:0]                          frac1_reg;
    logic signed [f2h_pkg::EXP_W-1:0]     e1_reg;
    f2h_pkg::cls_t                        cls1_reg;

    // stage 2 registers
    logic        v2_reg;
    logic        sgn2_reg;
    logic [14:0] body2_reg;
    logic        rnd2_reg;

    // stage 3 registers
    logic        v3_reg;
    logic [15:0] half3_reg;

    logic adv1, adv2, adv3;
    logic nan_adv;

    // stage 1 next values
    logic [7:0]                       bexp;
    logic signed [f2h_pkg::EXP_W-1:0] e_next;
    f2h_pkg::cls_t                    cls_next;

    // stage 2 next values
    logic [23:0] full;
    logic [4:0]  sh_m1;
    logic [23:0] shifted;
    logic [14:0] body_next;
    logic        rnd_next;

    assign adv3 = !v3_reg || !half_stall;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign single_stall = !adv1;

    assign bexp   = single_bits[30:23];
    assign e_next = $signed({1'b0, bexp}) - f2h_pkg::REBIAS;

    always_comb
    begin
        if (bexp == 8'hFF)
        begin
            cls_next = (single_bits[22:0] == 23'd0) ? f2h_pkg::CLS_INF : f2h_pkg::CLS_NAN;
        end
        else if (e_next < -9'sd10)
        begin
            cls_next = f2h_pkg::CLS_ZERO;
        end
        else if (e_next <= 9'sd0)
        begin
            cls_next = f2h_pkg::CLS_SUB;
        end
        else if (e_next >= 9'sd31)
        begin
            cls_next = f2h_pkg::CLS_INF;
        end
        else
        begin
            cls_next = f2h_pkg::CLS_NORM;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv1)
        begin
            v1_reg <= single_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && single_valid)
        begin
            sgn1_reg  <= single_bits[31];
            frac1_reg <= single_bits[22:0];
            e1_reg    <= e_next;
            cls1_reg  <= cls_next;
        end
    end

    // shift by one less than the subnormal shift keeps the round bit at bit 0
    assign full    = {1'b1, frac1_reg};
    assign sh_m1   = 5'(9'sd13 - e1_reg);
    assign shifted = full >> sh_m1;

    always_comb
    begin
        unique case (cls1_reg)
            f2h_pkg::CLS_ZERO:
            begin
                body_next = 15'd0;
                rnd_next  = 1'b0;
            end
            f2h_pkg::CLS_SUB:
            begin
                body_next = {5'd0, shifted[10:1]};
                rnd_next  = shifted[0];
            end
            f2h_pkg::CLS_NORM:
            begin
                body_next = {e1_reg[4:0], frac1_reg[22:13]};
                rnd_next  = frac1_reg[12];
            end
            f2h_pkg::CLS_INF:
            begin
                body_next = f2h_pkg::HALF_INF_BODY;
                rnd_next  = 1'b0;
            end
            f2h_pkg::CLS_NAN:
            begin
                body_next = f2h_pkg::HALF_INF_BODY | f2h_pkg::HALF_QUIET
                            | {5'd0, frac1_reg[22:13]};
                rnd_next  = 1'b0;
            end
            default:
            begin
                body_next = 15'd0;
                rnd_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv2)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && v1_reg)
        begin
            sgn2_reg  <= sgn1_reg;
            body2_reg <= body_next;
            rnd2_reg  <= rnd_next;
        end
    end

    // rounding carry ripples into the exponent field
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (adv3)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3 && v2_reg)
        begin
            half3_reg <= {sgn2_reg, body2_reg + {14'd0, rnd2_reg}};
        end
    end

    assign half_valid = v3_reg;
    assign half_bits  = half3_reg;

    assign nan_adv = v1_reg && adv2 && (cls1_reg == f2h_pkg::CLS_NAN);

    `F2H_ASSERT_NEXT(a_in_lands, clk, rst_n, single_valid && !single_stall, v1_reg)
    `F2H_ASSERT_NEXT(a_drain, clk, rst_n, v3_reg && !half_stall && !v2_reg, !half_valid)
    `F2H_ASSERT_NEXT(a_nan_body, clk, rst_n, nan_adv, body2_reg[14:9] == 6'h3F)

endmodule

### tb/f2h_board_pkg.sv
// scoreboard for the fp32 to fp16 encoder test: binary32 to binary16 prediction and result queue
// depends on f2h_pkg for the rebias and half constants
`timescale 1ns / 1ps

package f2h_board_pkg;

    class conversion_board;

        logic [15:0] pending_half[$];
        int unsigned failures;

        function new();
            failures = 0;
        endfunction

        // binary32 to binary16, nearest with ties away from zero
        function logic [15:0] to_half(logic [31:0] w);
            logic        sgn;
            logic [7:0]  bexp;
            logic [22:0] frac;
            int          e;
            int          sh;
            logic [23:0] full;
            logic [15:0] mag;
            logic [23:0] rnd;
            sgn  = w[31];
            bexp = w[30:23];
            frac = w[22:0];
            e    = int'(bexp) - int'(f2h_pkg::REBIAS);
            if (bexp == 8'hFF)
            begin
                if (frac == 23'h0)
                    return {sgn, f2h_pkg::HALF_INF_BODY};
                return {sgn, f2h_pkg::HALF_INF_BODY | f2h_pkg::HALF_QUIET
                             | {5'h0, frac[22:13]}};
            end
            if (e <= 0)
            begin
                if (e < -10)
                    return {sgn, 15'h0};
                full = {1'b1, frac};
                sh   = 14 - e;
                mag  = 16'(full >> sh);
                if (full[sh-1])
                    mag = mag + 16'd1;
                return {sgn, mag[14:0]};
            end
            if (e >= 31)
                return {sgn, f2h_pkg::HALF_INF_BODY};
            rnd = {1'b0, frac} + 24'h1000;
            if (rnd[23])
                return {sgn, 5'(e + 1), 10'h0};
            return {sgn, 5'(e), rnd[22:13]};
        endfunction

        function void note_single(logic [31:0] w);
            pending_half.push_back(to_half(w));
        endfunction

        function void check_half(logic [15:0] got);
            logic [15:0] want;
            if (pending_half.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("half word %h arrived with nothing pending", got);
                return;
            end
            want = pending_half.pop_front();
            if (got !== want)
            begin
                failures++;
                if (failures <= 10)
                    $display("half word mismatch: expected %h got %h", want, got);
            end
        endfunction

        function int unsigned outstanding();
            return pending_half.size();
        endfunction

    endclass

endpackage

### tb/fp32_to_fp16_encoder_test.sv
// top of the fp32 to fp16 encoder test: clock, reset, word drivers, monitor and watchdog
// depends on f2h_pkg, f2h_board_pkg and the fp32_to_fp16_encoder rtl
`timescale 1ns / 1ps

module fp32_to_fp16_encoder_test;

    localparam int unsigned QUIET_LIMIT = 3000;
    localparam int unsigned PHASE_ITEMS = 370;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        single_valid;
    logic        single_stall;
    logic [31:0] single_bits;
    logic        half_valid;
    logic        half_stall;
    logic [15:0] half_bits;

    f2h_board_pkg::conversion_board board;

    int unsigned idle_pct;
    int unsigned stall_pct;
    int unsigned hold_left;
    int unsigned quiet_cycles;

    fp32_to_fp16_encoder dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .single_valid (single_valid),
        .single_stall (single_stall),
        .single_bits  (single_bits),
        .half_valid   (half_valid),
        .half_stall   (half_stall),
        .half_bits    (half_bits)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic send_single(input logic [31:0] w);
        while ($urandom_range(99) < idle_pct)
        begin
            single_valid <= 1'b0;
            @(posedge clk);
        end
        single_valid <= 1'b1;
        single_bits  <= w;
        @(posedge clk);
        while (single_stall)
            @(posedge clk);
        board.note_single(w);
    endtask

    task automatic drain();
        single_valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_single();
        logic [12:0] round_tails[4];
        int unsigned roll;
        logic        sgn;
        logic [7:0]  bexp;
        logic [22:0] frac;
        round_tails = '{13'h0FFF, 13'h1000, 13'h1001, 13'h1FFF};
        roll = $urandom_range(99);
        sgn  = 1'($urandom);
        frac = 23'($urandom);
        if (roll < 20)
            return $urandom;
        if (roll < 60)
            bexp = 8'($urandom_range(98, 146));
        else if (roll < 75)
            bexp = 8'($urandom_range(100, 114));
        else if (roll < 90)
        begin
            bexp = 8'($urandom_range(100, 143));
            frac[12:0] = round_tails[$urandom_range(3)];
            if ($urandom_range(1) == 0)
                frac[22:13] = 10'h3FF;
        end
        else
        begin
            bexp = ($urandom_range(1) == 0) ? 8'h00 : 8'hFF;
            if ($urandom_range(2) == 0)
                frac = 23'h0;
        end
        return {sgn, bexp, frac};
    endfunction

    task automatic run_phase(input int unsigned send_idle, input int unsigned recv_stall,
                             input int unsigned count);
        idle_pct  = send_idle;
        stall_pct = recv_stall;
        repeat (count)
            send_single(pick_single());
        drain();
    endtask

    // receiver: random stall, or a counted hold-off when asked
    initial
    begin
        half_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                half_stall <= 1'b1;
                hold_left = hold_left - 1;
            end
            else
                half_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && half_valid && !half_stall)
            board.check_half(half_bits);
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((single_valid && !single_stall) || (half_valid && !half_stall))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
        end
        $display("fp32_to_fp16_encoder verification failed");
        $finish;
    end

    initial
    begin
        logic [31:0] directed[$];
        board        = new();
        idle_pct     = 0;
        stall_pct    = 0;
        hold_left    = 0;
        rst_n        <= 1'b0;
        single_valid <= 1'b0;
        single_bits  <= 32'h0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zeros, single subnormals, half subnormal edges, ties, carries, overflow, specials
        directed = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF,
                     32'h3300_0000, 32'h32FF_FFFF, 32'hB2FF_FFFF, 32'h387F_FFFF,
                     32'h3800_0000, 32'h3880_0000, 32'h3F80_0000, 32'hBF80_0000,
                     32'h3F80_1000, 32'h3F80_0FFF, 32'h3FFF_F000, 32'h477F_E000,
                     32'h477F_EFFF, 32'h477F_F000, 32'h4780_0000, 32'hFF7F_FFFF,
                     32'h7F80_0000, 32'hFF80_0000, 32'h7FFF_FFFF, 32'h7F80_0001,
                     32'hFFC0_0000};
        foreach (directed[i])
            send_single(directed[i]);
        drain();

        run_phase(0, 0, PHASE_ITEMS);
        run_phase(85, 0, PHASE_ITEMS);
        run_phase(0, 85, PHASE_ITEMS);
        run_phase(27, 27, PHASE_ITEMS);

        // long receiver hold-off while words keep coming, then wait for every result
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = 80;
        repeat (70)
            send_single(pick_single());
        drain();

        repeat (12)
            @(posedge clk);
        if (board.failures == 0)
            $display("fp32_to_fp16_encoder verification clean");
        else
            $display("fp32_to_fp16_encoder verification failed");
        $finish;
    end

endmodule
